>>> rtl/tanh_regularized_friction_force_assert.svh
// Assertion macros shared by the friction force RTL.
// Each macro expects the signals clk and rst_n in the scope where it is used.
`ifndef TANH_REGULARIZED_FRICTION_FORCE_ASSERT_SVH
`define TANH_REGULARIZED_FRICTION_FORCE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TRFF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TRFF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/trff_pkg.sv
// Shared types, constants and the tanh breakpoint table for the friction force block.
// Used by trff_core and tanh_regularized_friction_force; depends on nothing.
`timescale 1ns / 1ps

package trff_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRICTION_COEFF = 1'b0,
        REG_REF_VELOCITY   = 1'b1
    } reg_index_t;

    localparam logic [23:0] FRICTION_COEFF_RESET = 24'd0;
    localparam logic [30:0] REF_VELOCITY_RESET   = 31'd65536;

    // Stream widths
    localparam int IN_DATA_W  = 272;
    localparam int OUT_DATA_W = 96;

    // Pipeline stage map; each stage takes its input from the stage before it.
    localparam int ST_IN       = 0;
    localparam int ST_PROD     = 1;
    localparam int ST_DOT      = 2;
    localparam int ST_PROJ     = 3;
    localparam int ST_TAN      = 4;
    localparam int ST_SQ       = 5;
    localparam int ST_SUM      = 6;
    localparam int SQRT_STEPS  = 32;
    localparam int ST_SQRT0    = 7;
    localparam int ST_MAG      = ST_SQRT0 + SQRT_STEPS;
    localparam int XDIV_STEPS  = 20;
    localparam int ST_XDIV0    = ST_MAG + 1;
    localparam int ST_TANH     = ST_XDIV0 + XDIV_STEPS;
    localparam int ST_FMAG     = ST_TANH + 1;
    localparam int ST_FPROD    = ST_FMAG + 1;
    localparam int FDIV_STEPS  = 31;
    localparam int ST_FDIV0    = ST_FPROD + 1;
    localparam int ST_OUT      = ST_FDIV0 + FDIV_STEPS;
    localparam int NUM_STAGES  = ST_OUT + 1;

    localparam logic [5:0]  TANH_SEGMENTS = 6'd25;
    localparam logic [16:0] TANH_ONE      = 17'd65536;

    typedef struct packed {
        logic [23:0] friction_coeff;
        logic [30:0] ref_velocity;
    } cfg_t;

    // Input item; all fields are two's complement.
    typedef struct packed {
        logic [31:0] force_in_z;
        logic [31:0] force_in_y;
        logic [31:0] force_in_x;
        logic [31:0] normal_force;
        logic [15:0] normal_z;
        logic [15:0] normal_y;
        logic [15:0] normal_x;
        logic [31:0] rel_vel_z;
        logic [31:0] rel_vel_y;
        logic [31:0] rel_vel_x;
    } item_t;

    typedef struct packed {
        logic [31:0] force_out_z;
        logic [31:0] force_out_y;
        logic [31:0] force_out_x;
    } result_t;

    // Context that travels down the pipeline with each contact pair.
    typedef struct packed {
        logic [2:0][31:0] v;
        logic [2:0][15:0] n;
        logic [2:0][31:0] fin;
        logic [31:0]      nf;
        logic             act;
        logic [38:0]      fm1;
        logic [2:0][47:0] pr;
        logic [35:0]      vn;
        logic [2:0][51:0] proj;
        logic [2:0]       neg;
        logic [2:0][31:0] a;
        logic [2:0][63:0] sq;
        logic [63:0]      sx;
        logic [35:0]      srem;
        logic [31:0]      root;
        logic [31:0]      mag;
        logic             pass;
        logic             xovf;
        logic [31:0]      xrem;
        logic [19:0]      xq;
        logic [16:0]      th;
        logic [30:0]      f;
        logic [2:0][31:0] drem;
        logic [2:0][62:0] dsh;
        logic [2:0][30:0] dq;
        logic [2:0][31:0] fout;
    } ctx_t;

    // round(65536 * tanh(k / 4)) for k = 0 .. 25
    function automatic logic [16:0] tanh_point(input logic [4:0] idx);
        logic [16:0] val;
        case (idx)
            5'd0:    val = 17'd0;
            5'd1:    val = 17'd16051;
            5'd2:    val = 17'd30285;
            5'd3:    val = 17'd41625;
            5'd4:    val = 17'd49912;
            5'd5:    val = 17'd55593;
            5'd6:    val = 17'd59320;
            5'd7:    val = 17'd61694;
            5'd8:    val = 17'd63179;
            5'd9:    val = 17'd64096;
            5'd10:   val = 17'd64659;
            5'd11:   val = 17'd65003;
            5'd12:   val = 17'd65212;
            5'd13:   val = 17'd65339;
            5'd14:   val = 17'd65417;
            5'd15:   val = 17'd65464;
            5'd16:   val = 17'd65492;
            5'd17:   val = 17'd65509;
            5'd18:   val = 17'd65520;
            5'd19:   val = 17'd65526;
            5'd20:   val = 17'd65530;
            5'd21:   val = 17'd65532;
            5'd22:   val = 17'd65534;
            5'd23:   val = 17'd65535;
            5'd24:   val = 17'd65535;
            5'd25:   val = 17'd65536;
            default: val = 17'd65536;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/trff_core.sv
// Stall-gated datapath pipeline of the friction force block.
// Depends on trff_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "tanh_regularized_friction_force_assert.svh"

module trff_core
    import trff_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_vld,
    input  item_t   in_item,
    input  cfg_t    cfg,
    output logic    out_vld,
    output result_t out_res
);

    ctx_t        st_reg  [NUM_STAGES];
    ctx_t        st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic [30:0] vref_eff;

    // A zero reference speed acts as the smallest step.
    assign vref_eff = (cfg.ref_velocity == 31'd0) ? 31'd1 : cfg.ref_velocity;

    // Capture the transaction fields and decide whether friction applies at all.
    always_comb
    begin
        st_next[ST_IN]        = st_reg[ST_IN];
        st_next[ST_IN].v[0]   = in_item.rel_vel_x;
        st_next[ST_IN].v[1]   = in_item.rel_vel_y;
        st_next[ST_IN].v[2]   = in_item.rel_vel_z;
        st_next[ST_IN].n[0]   = in_item.normal_x;
        st_next[ST_IN].n[1]   = in_item.normal_y;
        st_next[ST_IN].n[2]   = in_item.normal_z;
        st_next[ST_IN].fin[0] = in_item.force_in_x;
        st_next[ST_IN].fin[1] = in_item.force_in_y;
        st_next[ST_IN].fin[2] = in_item.force_in_z;
        st_next[ST_IN].nf     = in_item.normal_force;
        st_next[ST_IN].act    = (cfg.friction_coeff != 24'd0) && !in_item.normal_force[31]
                                && (in_item.normal_force != 32'd0);
    end

    for (genvar i = 1; i < NUM_STAGES; i++)
    begin : g_stage
        ctx_t nx;

        if (i == ST_PROD)
        begin : g_prod
            logic signed [47:0] p [3];
            logic [54:0]        cm;
            // Velocity times normal per axis; coefficient times normal force.
            always_comb
            begin
                nx = st_reg[i-1];
                for (int k = 0; k < 3; k++)
                begin
                    p[k]     = $signed(st_reg[i-1].v[k]) * $signed(st_reg[i-1].n[k]);
                    nx.pr[k] = p[k];
                end
                cm     = cfg.friction_coeff * st_reg[i-1].nf[30:0];
                nx.fm1 = cm[54:16];
            end
        end
        else if (i == ST_DOT)
        begin : g_dot
            logic signed [49:0] dot;
            // Normal velocity, floored back to Q16.16.
            always_comb
            begin
                nx  = st_reg[i-1];
                dot = $signed({{2{st_reg[i-1].pr[0][47]}}, st_reg[i-1].pr[0]})
                    + $signed({{2{st_reg[i-1].pr[1][47]}}, st_reg[i-1].pr[1]})
                    + $signed({{2{st_reg[i-1].pr[2][47]}}, st_reg[i-1].pr[2]});
                nx.vn = dot[49:14];
            end
        end
        else if (i == ST_PROJ)
        begin : g_proj
            logic signed [51:0] q [3];
            // Normal velocity projected back onto each axis.
            always_comb
            begin
                nx = st_reg[i-1];
                for (int k = 0; k < 3; k++)
                begin
                    q[k]       = $signed(st_reg[i-1].vn) * $signed(st_reg[i-1].n[k]);
                    nx.proj[k] = q[k];
                end
            end
        end
        else if (i == ST_TAN)
        begin : g_tan
            logic signed [38:0] d   [3];
            logic [31:0]        vt  [3];
            // Tangential slip, saturated to 32 bits, split into sign and magnitude.
            always_comb
            begin
                nx = st_reg[i-1];
                for (int k = 0; k < 3; k++)
                begin
                    d[k] = $signed({{7{st_reg[i-1].v[k][31]}}, st_reg[i-1].v[k]})
                         - $signed({st_reg[i-1].proj[k][51], st_reg[i-1].proj[k][51:14]});
                    if (d[k][38:31] == 8'h00 || d[k][38:31] == 8'hFF)
                    begin
                        vt[k] = d[k][31:0];
                    end
                    else if (d[k][38])
                    begin
                        vt[k] = 32'h8000_0000;
                    end
                    else
                    begin
                        vt[k] = 32'h7FFF_FFFF;
                    end
                    nx.neg[k] = vt[k][31];
                    nx.a[k]   = vt[k][31] ? (~vt[k] + 32'd1) : vt[k];
                end
            end
        end
        else if (i == ST_SQ)
        begin : g_sq
            // Squares of the slip components.
            always_comb
            begin
                nx = st_reg[i-1];
                for (int k = 0; k < 3; k++)
                begin
                    nx.sq[k] = st_reg[i-1].a[k] * st_reg[i-1].a[k];
                end
            end
        end
        else if (i == ST_SUM)
        begin : g_sum
            // Squared slip magnitude; three squares of at most 2^62 fit in 64 bits.
            always_comb
            begin
                nx      = st_reg[i-1];
                nx.sx   = st_reg[i-1].sq[0] + st_reg[i-1].sq[1] + st_reg[i-1].sq[2];
                nx.srem = 36'd0;
                nx.root = 32'd0;
            end
        end
        else if (i >= ST_SQRT0 && i < ST_MAG)
        begin : g_sqrt
            logic [35:0] remsh;
            logic [35:0] trial;
            // One root bit per stage: bring down two radicand bits, try root*4+1.
            always_comb
            begin
                nx    = st_reg[i-1];
                remsh = {st_reg[i-1].srem[33:0], st_reg[i-1].sx[63:62]};
                trial = {2'b00, st_reg[i-1].root, 2'b01};
                if (remsh >= trial)
                begin
                    nx.srem = remsh - trial;
                    nx.root = {st_reg[i-1].root[30:0], 1'b1};
                end
                else
                begin
                    nx.srem = remsh;
                    nx.root = {st_reg[i-1].root[30:0], 1'b0};
                end
                nx.sx = {st_reg[i-1].sx[61:0], 2'b00};
            end
        end
        else if (i == ST_MAG)
        begin : g_mag
            logic [31:0] head;
            // Slip magnitude; set up mag * 2^16 / ref_velocity with 20 quotient bits.
            always_comb
            begin
                nx      = st_reg[i-1];
                head    = {4'd0, st_reg[i-1].root[31:4]};
                nx.mag  = st_reg[i-1].root;
                nx.pass = !st_reg[i-1].act || (st_reg[i-1].root == 32'd0);
                nx.xovf = head >= {1'b0, vref_eff};
                nx.xrem = head;
                nx.xq   = 20'd0;
            end
        end
        else if (i >= ST_XDIV0 && i < ST_TANH)
        begin : g_xdiv
            localparam int J = XDIV_STEPS - 1 - (i - ST_XDIV0);
            logic        dbit;
            logic [31:0] remsh;
            if (J >= 16)
            begin : g_hi
                assign dbit = st_reg[i-1].mag[J-16];
            end
            else
            begin : g_lo
                assign dbit = 1'b0;
            end
            // One quotient bit of the scaled slip per stage.
            always_comb
            begin
                nx    = st_reg[i-1];
                remsh = {st_reg[i-1].xrem[30:0], dbit};
                if (remsh >= {1'b0, vref_eff})
                begin
                    nx.xrem = remsh - {1'b0, vref_eff};
                    nx.xq   = {st_reg[i-1].xq[18:0], 1'b1};
                end
                else
                begin
                    nx.xrem = remsh;
                    nx.xq   = {st_reg[i-1].xq[18:0], 1'b0};
                end
            end
        end
        else if (i == ST_TANH)
        begin : g_tanh
            logic [5:0]  seg;
            logic [16:0] t0;
            logic [16:0] t1;
            logic [16:0] diff;
            logic [27:0] lin;
            // Table lookup with linear interpolation over quarter-unit segments.
            always_comb
            begin
                nx   = st_reg[i-1];
                seg  = st_reg[i-1].xq[19:14];
                t0   = tanh_point(seg[4:0]);
                t1   = tanh_point(seg[4:0] + 5'd1);
                diff = t1 - t0;
                lin  = diff[13:0] * st_reg[i-1].xq[13:0];
                if (st_reg[i-1].xovf || seg >= TANH_SEGMENTS)
                begin
                    nx.th = TANH_ONE;
                end
                else
                begin
                    nx.th = t0 + {3'd0, lin[27:14]};
                end
            end
        end
        else if (i == ST_FMAG)
        begin : g_fmag
            logic [55:0] fp;
            // Friction magnitude, saturated to the largest positive Q16.16.
            always_comb
            begin
                nx = st_reg[i-1];
                fp = st_reg[i-1].fm1 * st_reg[i-1].th;
                if (fp[55:47] != 9'd0)
                begin
                    nx.f = 31'h7FFF_FFFF;
                end
                else
                begin
                    nx.f = fp[46:16];
                end
            end
        end
        else if (i == ST_FPROD)
        begin : g_fprod
            logic [62:0] prod [3];
            // Friction times slip component; quotient by mag stays below 2^31.
            always_comb
            begin
                nx = st_reg[i-1];
                for (int k = 0; k < 3; k++)
                begin
                    prod[k]    = st_reg[i-1].f * st_reg[i-1].a[k];
                    nx.drem[k] = prod[k][62:31];
                    nx.dsh[k]  = {prod[k][30:0], 32'd0};
                    nx.dq[k]   = 31'd0;
                end
            end
        end
        else if (i >= ST_FDIV0 && i < ST_OUT)
        begin : g_fdiv
            logic [32:0] remsh [3];
            // One quotient bit per lane per stage.
            always_comb
            begin
                nx = st_reg[i-1];
                for (int k = 0; k < 3; k++)
                begin
                    remsh[k]  = {st_reg[i-1].drem[k], st_reg[i-1].dsh[k][62]};
                    nx.dsh[k] = {st_reg[i-1].dsh[k][61:0], 1'b0};
                    if (remsh[k] >= {1'b0, st_reg[i-1].mag})
                    begin
                        remsh[k]   = remsh[k] - {1'b0, st_reg[i-1].mag};
                        nx.dq[k]   = {st_reg[i-1].dq[k][29:0], 1'b1};
                    end
                    else
                    begin
                        nx.dq[k]   = {st_reg[i-1].dq[k][29:0], 1'b0};
                    end
                    nx.drem[k] = remsh[k][31:0];
                end
            end
        end
        else if (i == ST_OUT)
        begin : g_out
            logic signed [33:0] c [3];
            logic signed [33:0] d [3];
            // Subtract the signed friction component and saturate.
            always_comb
            begin
                nx = st_reg[i-1];
                for (int k = 0; k < 3; k++)
                begin
                    c[k] = st_reg[i-1].neg[k] ? -$signed({3'd0, st_reg[i-1].dq[k]})
                                              :  $signed({3'd0, st_reg[i-1].dq[k]});
                    d[k] = $signed({{2{st_reg[i-1].fin[k][31]}}, st_reg[i-1].fin[k]}) - c[k];
                    if (st_reg[i-1].pass)
                    begin
                        nx.fout[k] = st_reg[i-1].fin[k];
                    end
                    else if (d[k][33:31] == 3'b000 || d[k][33:31] == 3'b111)
                    begin
                        nx.fout[k] = d[k][31:0];
                    end
                    else if (d[k][33])
                    begin
                        nx.fout[k] = 32'h8000_0000;
                    end
                    else
                    begin
                        nx.fout[k] = 32'h7FFF_FFFF;
                    end
                end
            end
        end
        else
        begin : g_hold
            always_comb
            begin
                nx = st_reg[i-1];
            end
        end

        assign st_next[i] = nx;
    end

    // Valid bits; the whole pipeline advances together when enabled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], in_vld};
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign out_vld             = vld_reg[ST_OUT];
    assign out_res.force_out_x = st_reg[ST_OUT].fout[0];
    assign out_res.force_out_y = st_reg[ST_OUT].fout[1];
    assign out_res.force_out_z = st_reg[ST_OUT].fout[2];

    // A bypassed pair leaves with its input force untouched.
    `TRFF_ASSERT_IMP(a_pass_keeps_force, vld_reg[ST_OUT] && st_reg[ST_OUT].pass,
        st_reg[ST_OUT].fout == st_reg[ST_OUT].fin, "bypassed pair changed its force")
    // Each friction component is at most the friction magnitude.
    `TRFF_ASSERT_IMP(a_comp_le_mag, vld_reg[ST_OUT-1] && !st_reg[ST_OUT-1].pass,
        st_reg[ST_OUT-1].dq[0] <= st_reg[ST_OUT-1].f && st_reg[ST_OUT-1].dq[1] <= st_reg[ST_OUT-1].f && st_reg[ST_OUT-1].dq[2] <= st_reg[ST_OUT-1].f,
        "friction component exceeds magnitude")

endmodule

>>> rtl/tanh_regularized_friction_force.sv
// Top level of the tanh-regularized Coulomb friction block: stream ports,
// configuration registers and output buffer. Depends on trff_pkg and trff_core.
`timescale 1ns / 1ps
`include "tanh_regularized_friction_force_assert.svh"

// One contact pair per transaction, one result per pair, one pair accepted every
// cycle while s_tready is high. A pair's result shows on m_tvalid after it passes
// the datapath pipeline and the output register; the pipeline's depth comes chiefly
// from its 32 square-root stages and its 20-stage and 31-stage long divisions,
// each resolving one bit per stage. A two-entry output buffer lets one more result
// arrive while the first waits; after that s_tready drops until m_tready frees a
// slot. Write friction_coeff and ref_velocity only while no pair is in flight.
module tanh_regularized_friction_force
    import trff_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // rel_vel_x, rel_vel_y, rel_vel_z, normal_x, normal_y, normal_z,
    // normal_force, force_in_x, force_in_y, force_in_z (from bit 0 up)
    input  logic [IN_DATA_W-1:0]   s_tdata,
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // force_out_x, force_out_y, force_out_z (from bit 0 up)
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    item_t   in_item;
    logic    en;
    logic    pipe_vld;
    result_t pipe_res;
    logic    out_vld_reg;
    logic    out_vld_next;
    logic    skid_vld_reg;
    logic    skid_vld_next;
    result_t out_res_reg;
    result_t out_res_next;
    result_t skid_res_reg;
    result_t skid_res_next;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_FRICTION_COEFF: cfg_next.friction_coeff = cfg_data[23:0];
                REG_REF_VELOCITY:   cfg_next.ref_velocity   = cfg_data[30:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.friction_coeff <= FRICTION_COEFF_RESET;
            cfg_reg.ref_velocity   <= REF_VELOCITY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The pipeline moves whenever the skid slot is free.
    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign in_item  = item_t'(s_tdata);

    trff_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_tvalid),
        .in_item (in_item),
        .cfg     (cfg_reg),
        .out_vld (pipe_vld),
        .out_res (pipe_res)
    );

    // Output register plus skid slot.
    always_comb
    begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        out_res_next  = out_res_reg;
        skid_res_next = skid_res_reg;
        if (skid_vld_reg)
        begin
            if (m_tready)
            begin
                out_res_next  = skid_res_reg;
                skid_vld_next = 1'b0;
            end
        end
        else if (!out_vld_reg || m_tready)
        begin
            out_vld_next = pipe_vld;
            out_res_next = pipe_res;
        end
        else if (pipe_vld)
        begin
            skid_vld_next = 1'b1;
            skid_res_next = pipe_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_res_reg;

    // The skid slot only fills behind a waiting result.
    `TRFF_ASSERT_IMP(a_skid_behind_out, skid_vld_reg, out_vld_reg,
        "skid slot holds a result with the output empty")
    // A result arriving at a stalled output is parked, not dropped.
    `TRFF_ASSERT_NXT(a_park_on_stall, out_vld_reg && !m_tready && !skid_vld_reg && pipe_vld,
        skid_vld_reg, "result dropped at stalled output")
    // With both slots full and no transaction out, input stays closed.
    `TRFF_ASSERT_NXT(a_full_blocks_input, skid_vld_reg && !m_tready, !s_tready,
        "input opened while output buffer full")

endmodule
